>>> hw/rtl/s2cf_pkg.sv
// ----------------------------------------------------------------------------
// s2cf_pkg
// shared widths and constants for the single to custom float converter
// ----------------------------------------------------------------------------
package s2cf_pkg;

   localparam int IEEE_W       = 32;
   localparam int IEEE_EXP_W   = 8;
   localparam int IEEE_FRAC_W  = 23;
   localparam int SIG_W        = IEEE_FRAC_W + 1;
   localparam int PACKED_W     = 32;

   // biased exponent minus this gives the exponent at the leading one
   localparam int IEEE_BIAS_M1 = 126;

   // signed working width for the exponent, unsigned width for the shift
   localparam int EXPC_W       = 10;
   localparam int SHIFT_W      = 9;
   localparam int SHIFT_SEL_W  = 5;

   // shifts of this size or more clear the mantissa
   localparam int SHIFT_LIMIT  = 25;

   localparam int MANT_BITS_DEF = 23;
   localparam int EXP_BITS_DEF  = 8;

endpackage

>>> hw/rtl/s2cf_convert.sv
// ----------------------------------------------------------------------------
// s2cf_convert
// combinational conversion of one ieee single word to the packed custom float
// ----------------------------------------------------------------------------
module s2cf_convert import s2cf_pkg::*; #(
   parameter int MANT_BITS = MANT_BITS_DEF,
   parameter int EXP_BITS  = EXP_BITS_DEF
) (
   input  logic [IEEE_W-1:0]   ieee_bits,
   output logic [PACKED_W-1:0] packed_float,
   output logic                exponent_overflow
);

   localparam logic signed [EXPC_W-1:0] EMIN     = EXPC_W'(-(2 ** (EXP_BITS - 1)));
   localparam logic signed [EXPC_W-1:0] EMAX     = EXPC_W'((2 ** (EXP_BITS - 1)) - 1);
   localparam logic signed [EXPC_W-1:0] E_OFFSET = EXPC_W'(IEEE_BIAS_M1 + MANT_BITS);
   localparam logic [SHIFT_W-1:0]       SH_BASE  = SHIFT_W'(SIG_W - MANT_BITS);

   logic                          sign;
   logic [IEEE_EXP_W-1:0]         bexp;
   logic [IEEE_FRAC_W-1:0]        frac;
   logic                          is_zero;
   logic                          is_sub;
   logic [IEEE_EXP_W-1:0]         bexp_eff;
   logic [SIG_W-1:0]              sig;
   logic signed [EXPC_W-1:0]      e_raw;
   logic                          under;
   logic signed [EXPC_W-1:0]      e_clamp;
   logic signed [EXPC_W-1:0]      deficit;
   logic [SHIFT_W-1:0]            shift;
   logic                          wipe;
   logic [SHIFT_SEL_W-1:0]        sh;
   logic [SIG_W-1:0]              sig_sh;
   logic [SIG_W-1:0]              sig_rb;
   logic [SIG_W:0]                mant_rnd;
   logic                          carry;
   logic [SIG_W:0]                mant_fin;
   logic signed [EXPC_W-1:0]      e_fin;
   logic [PACKED_W-1:0]           word;

   assign sign     = ieee_bits[IEEE_W-1];
   assign bexp     = ieee_bits[IEEE_W-2 -: IEEE_EXP_W];
   assign frac     = ieee_bits[IEEE_FRAC_W-1:0];
   assign is_zero  = (bexp == '0) && (frac == '0);
   assign is_sub   = (bexp == '0);
   assign bexp_eff = is_sub ? IEEE_EXP_W'(1) : bexp;
   assign sig      = {!is_sub, frac};

   assign e_raw    = $signed({{(EXPC_W-IEEE_EXP_W){1'b0}}, bexp_eff}) - E_OFFSET;
   assign under    = e_raw < EMIN;
   assign deficit  = EMIN - e_raw;
   assign e_clamp  = under ? EMIN : e_raw;
   assign shift    = under ? (SH_BASE + deficit[SHIFT_W-1:0]) : SH_BASE;
   assign wipe     = shift >= SHIFT_W'(SHIFT_LIMIT);
   assign sh       = shift[SHIFT_SEL_W-1:0];

   // truncate, then add the last bit shifted out
   assign sig_sh   = sig >> sh;
   assign sig_rb   = sig >> (sh - SHIFT_SEL_W'(1));
   assign mant_rnd = wipe ? '0 : ({1'b0, sig_sh} + {{SIG_W{1'b0}}, sig_rb[0]});

   // rounding carry into bit MANT_BITS renormalizes
   assign carry    = mant_rnd[MANT_BITS];
   assign mant_fin = carry ? (mant_rnd >> 1) : mant_rnd;
   assign e_fin    = carry ? (e_clamp + EXPC_W'(1)) : e_clamp;

   assign word = ({{(PACKED_W-1){1'b0}}, sign} << (MANT_BITS + EXP_BITS))
               | ({{(PACKED_W-EXP_BITS){1'b0}}, e_fin[EXP_BITS-1:0]} << MANT_BITS)
               | {{(PACKED_W-MANT_BITS){1'b0}}, mant_fin[MANT_BITS-1:0]};

   assign packed_float      = is_zero ? (PACKED_W'(1) << (MANT_BITS + EXP_BITS - 1)) : word;
   assign exponent_overflow = !is_zero && (e_fin > EMAX);

endmodule

>>> hw/rtl/single_to_custom_float.sv
// ----------------------------------------------------------------------------
// single_to_custom_float
// ieee single to packed custom float converter with valid/ready channels
// ----------------------------------------------------------------------------
// One beat in, one beat out. The word is captured in an input register, the
// conversion runs as one combinational pass, and the result lands in an output
// register that drives rsp_valid, and a new beat is taken every cycle while
// the response side keeps up. The two registers form a two-entry pipeline, so
// one finished result can wait on rsp_ready while the next word is already held.
// ----------------------------------------------------------------------------
module single_to_custom_float import s2cf_pkg::*; #(
   parameter int MANT_BITS = MANT_BITS_DEF,
   parameter int EXP_BITS  = EXP_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [IEEE_W-1:0]   req_ieee_bits,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PACKED_W-1:0] rsp_packed_float,
   output logic                rsp_exponent_overflow
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [IEEE_W-1:0]   in_bits_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [PACKED_W-1:0] out_packed_ff;
   logic                out_ovf_ff;
   logic [PACKED_W-1:0] conv_packed;
   logic                conv_ovf;
   logic                out_load;
   logic                in_load;

   s2cf_convert #(
      .MANT_BITS (MANT_BITS),
      .EXP_BITS  (EXP_BITS)
   ) u_convert (
      .ieee_bits         (in_bits_ff),
      .packed_float      (conv_packed),
      .exponent_overflow (conv_ovf)
   );

   assign out_load  = !out_valid_ff || rsp_ready;
   assign in_load   = !in_valid_ff || out_load;
   assign req_ready = in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_bits_ff <= req_ieee_bits;
      end
      if (out_load && in_valid_ff) begin
         out_packed_ff <= conv_packed;
         out_ovf_ff    <= conv_ovf;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_packed_float      = out_packed_ff;
   assign rsp_exponent_overflow = out_ovf_ff;

endmodule

>>> tb/tb_single_to_custom_float.sv
// ----------------------------------------------------------------------------
// tb_single_to_custom_float
// self-checking bench for the ieee single to custom float converter
// ----------------------------------------------------------------------------
// Words go in over the req channel. Each accepted beat is converted by a model
// in the bench and queued, and each rsp beat is checked in order against the
// oldest queued result. Stimulus covers zeros, subnormals, the exponent clamp,
// rounding carries, infinities and NaNs, followed by random words sent in
// bursts. The response side stalls on its own pattern, holds off once long
// enough to back the input up, and the sender waits once for a full drain.
// ----------------------------------------------------------------------------
module tb_single_to_custom_float;
   import s2cf_pkg::*;

   localparam int MANT_W         = MANT_BITS_DEF;
   localparam int EXP_W          = EXP_BITS_DEF;
   localparam int CLK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int HOLD_LEN       = 240;
   localparam int DRAIN_TAIL     = 10;

   typedef struct {
      logic [IEEE_W-1:0]   word;
      logic [PACKED_W-1:0] packed_float;
      logic                overflow;
   } conv_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [IEEE_W-1:0]   req_ieee_bits;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PACKED_W-1:0] rsp_packed_float;
   logic                rsp_exponent_overflow;

   conv_result_type pending_results[$];
   conv_result_type want;

   int mismatch_count = 0;
   int n_accepted     = 0;
   int n_checked      = 0;
   int n_in_stalls    = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int rx_mode        = 0;
   int rx_run         = 0;
   int rx_phase       = 0;

   single_to_custom_float #(
      .MANT_BITS (MANT_W),
      .EXP_BITS  (EXP_W)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_ieee_bits         (req_ieee_bits),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_packed_float      (rsp_packed_float),
      .rsp_exponent_overflow (rsp_exponent_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic conv_result_type ieee_to_custom(input logic [IEEE_W-1:0] word);
      conv_result_type     r;
      int                  bexp;
      int                  e;
      int                  emin;
      int                  emax;
      int unsigned         sig;
      int unsigned         mant;
      int unsigned         shift;
      logic [PACKED_W-1:0] e_field;
      r.word = word;
      emin   = -(1 << (EXP_W - 1));
      emax   = (1 << (EXP_W - 1)) - 1;
      bexp   = int'(word[30:23]);
      sig    = int'(word[22:0]);
      if (bexp == 0 && sig == 0) begin
         r.packed_float = 32'd1 << (MANT_W + EXP_W - 1);
         r.overflow     = 1'b0;
         return r;
      end
      if (bexp == 0)
         bexp = 1;
      else
         sig = sig | 32'h0080_0000;
      e     = bexp - IEEE_BIAS_M1 - MANT_W;
      shift = SIG_W - MANT_W;
      if (e < emin) begin
         shift = shift + (emin - e);
         e     = emin;
      end
      if (shift >= SHIFT_LIMIT)
         mant = 0;
      else
         mant = (sig >> shift) + ((sig >> (shift - 1)) & 1);
      if (mant >= (32'd1 << MANT_W)) begin
         mant = mant >> 1;
         e    = e + 1;
      end
      r.overflow     = (e > emax);
      e_field        = 32'(e) & ((32'd1 << EXP_W) - 1);
      r.packed_float = (32'(word[31]) << (MANT_W + EXP_W)) | (e_field << MANT_W)
                     | (32'(mant) & ((32'd1 << MANT_W) - 1));
      return r;
   endfunction

   // random words weighted toward the corners of the conversion
   function automatic logic [IEEE_W-1:0] random_word();
      logic [IEEE_W-1:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         4: w[30:23] = 8'd0;
         5: w[30:23] = 8'($urandom_range(0, 25));
         6: w[22:0]  = '1;
         7: w[30:23] = 8'hFF;
         8: w[30:23] = $urandom_range(0, 1) ? 8'd1 : 8'd254;
         9: begin
            w[30:23] = 8'($urandom_range(0, 22));
            w[22:0]  = $urandom_range(0, 1) ? 23'h7F_FFFF : 23'($urandom_range(0, 7));
         end
         default: ;
      endcase
      return w;
   endfunction

   // scoreboard: check the rsp beat first, then queue the req beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result packed_float=%h overflow=%b", $time,
                        rsp_packed_float, rsp_exponent_overflow);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               n_checked++;
               if (rsp_packed_float !== want.packed_float) begin
                  $display("%0t: packed_float for %h expected %h actual %h", $time,
                           want.word, want.packed_float, rsp_packed_float);
                  mismatch_count++;
               end
               if (rsp_exponent_overflow !== want.overflow) begin
                  $display("%0t: exponent_overflow for %h expected %b actual %b", $time,
                           want.word, want.overflow, rsp_exponent_overflow);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(ieee_to_custom(req_ieee_bits));
            n_accepted++;
         end
         if (req_valid && !req_ready)
            n_in_stalls++;
      end
   end

   // response side: long hold-offs on request, otherwise its own stall pattern
   always @(posedge clock) begin
      rx_phase <= rx_phase + 1;
      if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_LEN;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_run == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_run  <= $urandom_range(20, 80);
         end else begin
            rx_run <= rx_run - 1;
         end
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (rx_phase % 3) != 0;
         endcase
      end
   end

   task automatic send_word(input logic [IEEE_W-1:0] w);
      req_valid     <= 1'b1;
      req_ieee_bits <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_input(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      idle_input(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic send_bursts(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_word(random_word());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0)
            idle_input(gap);
      end
      idle_input(1);
   endtask

   task automatic test_corner_words();
      logic [IEEE_W-1:0] corners[] = '{
         32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002,
         32'h0000_0003, 32'h807F_FFFF, 32'h0020_0000, 32'h0080_0000,
         32'h0A00_0000, 32'h0A7F_FFFF, 32'h0A80_0000, 32'h3F80_0000,
         32'hBF80_0000, 32'h3F80_0001, 32'h4000_0001, 32'h3FFF_FFFF,
         32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
         32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
      };
      foreach (corners[i])
         send_word(corners[i]);
      idle_input(1);
   endtask

   task automatic test_random_stream();
      send_bursts(1000);
   endtask

   task automatic test_output_hold();
      hold_requests = hold_requests + 1;
      for (int i = 0; i < 60; i++)
         send_word(random_word());
      idle_input(1);
   endtask

   task automatic test_drain_pause();
      send_bursts(80);
      wait_for_drain();
      send_bursts(80);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ieee_bits = '0;
      rsp_ready     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_words();
      test_random_stream();
      test_output_hold();
      test_drain_pause();

      wait_for_drain();
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         mismatch_count++;
      end
      $display("converted %0d words, %0d results checked, %0d mismatches",
               n_accepted, n_checked, mismatch_count);
      $display("input held off for %0d cycles under output backpressure", n_in_stalls);
      if (mismatch_count == 0)
         $display("** single_to_custom_float: PASSED **");
      else
         $display("** single_to_custom_float: FAILED **");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("** single_to_custom_float: FAILED **");
      $finish;
   end

endmodule
